// ----- design/ffcd_pkg.sv -----
// ffcd_pkg: shared types and constants of the fixed frame command decoder.
// Standalone; used by ffcd_decode, ffcd_out_buf and fixed_frame_command_decoder.

package ffcd_pkg;

    // frame layout: head, command, data one, data two, tail
    localparam int unsigned FRAME_LEN  = 5;
    localparam int unsigned POS_W      = $clog2(FRAME_LEN);
    localparam int unsigned BODY_LEN   = FRAME_LEN - 2;
    localparam int unsigned BODY_IDX_W = $clog2(BODY_LEN);
    localparam int unsigned NUM_EVENTS = 5;

    localparam logic [7:0] DATA_EVENT = 8'hAA;
    localparam logic [7:0] DATA_MARK2 = 8'h22;
    localparam logic [7:0] DATA_MARK3 = 8'h33;

    // register reset values
    localparam logic [7:0] HEAD_RST     = 8'hEE;
    localparam logic [7:0] TAIL_RST     = 8'hFF;
    localparam logic [7:0] STRAIGHT_RST = 8'h01;
    localparam logic [7:0] ARC_RST      = 8'h02;
    localparam logic [7:0] FOUND_RST    = 8'h03;
    localparam logic [7:0] LOST_RST     = 8'h04;
    localparam logic [7:0] CORNER_RST   = 8'h05;
    localparam logic [7:0] MARKER_RST   = 8'h06;

    typedef enum logic [2:0] {
        CFG_HEAD     = 3'd0,
        CFG_TAIL     = 3'd1,
        CFG_STRAIGHT = 3'd2,
        CFG_ARC      = 3'd3,
        CFG_FOUND    = 3'd4,
        CFG_LOST     = 3'd5,
        CFG_CORNER   = 3'd6,
        CFG_MARKER   = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ACT_BYTE    = 2'd0,
        ACT_CONSUME = 2'd1,
        ACT_FETCH   = 2'd2,
        ACT_STATUS  = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        KIND_NONE     = 4'd0,
        KIND_INVALID  = 4'd1,
        KIND_STRAIGHT = 4'd2,
        KIND_ARC      = 4'd3,
        KIND_FOUND    = 4'd4,
        KIND_LOST     = 4'd5,
        KIND_CORNER   = 4'd6,
        KIND_MARK2    = 4'd7,
        KIND_MARK3    = 4'd8
    } kind_t;

    // command codes as programmed
    typedef struct packed {
        logic [7:0] straight;
        logic [7:0] arc;
        logic [7:0] found;
        logic [7:0] lost;
        logic [7:0] corner;
        logic [7:0] marker;
    } codes_t;

    // one result beat
    typedef struct packed {
        logic                  frame_done;
        kind_t                 kind;
        logic [7:0]            command;
        logic [7:0]            data_one;
        logic [7:0]            data_two;
        logic                  new_frame;
        logic [NUM_EVENTS-1:0] events;
        logic                  taken;
    } result_t;

endpackage

// ----- design/ffcd_decode.sv -----
// ffcd_decode: message kind decode from command and data bytes.
// Depends on ffcd_pkg (codes_t, kind_t, data patterns).

module ffcd_decode
(
    input  ffcd_pkg::codes_t                     codes,
    input  logic [7:0]                           command,
    input  logic [7:0]                           data_one,
    input  logic [7:0]                           data_two,
    output ffcd_pkg::kind_t                      kind,
    output logic [ffcd_pkg::NUM_EVENTS-1:0]      event_set
);

    logic is_event;
    logic is_mark2;
    logic is_mark3;

    assign is_event = (data_one == ffcd_pkg::DATA_EVENT) && (data_two == ffcd_pkg::DATA_EVENT);
    assign is_mark2 = (data_one == ffcd_pkg::DATA_MARK2) && (data_two == ffcd_pkg::DATA_MARK2);
    assign is_mark3 = (data_one == ffcd_pkg::DATA_MARK3) && (data_two == ffcd_pkg::DATA_MARK3);

    // first matching code wins
    always_comb
    begin
        kind = ffcd_pkg::KIND_INVALID;
        if (command == codes.straight)
        begin
            kind = ffcd_pkg::KIND_STRAIGHT;
        end
        else if (command == codes.arc)
        begin
            kind = ffcd_pkg::KIND_ARC;
        end
        else if (command == codes.found)
        begin
            kind = is_event ? ffcd_pkg::KIND_FOUND : ffcd_pkg::KIND_INVALID;
        end
        else if (command == codes.lost)
        begin
            kind = is_event ? ffcd_pkg::KIND_LOST : ffcd_pkg::KIND_INVALID;
        end
        else if (command == codes.corner)
        begin
            kind = is_event ? ffcd_pkg::KIND_CORNER : ffcd_pkg::KIND_INVALID;
        end
        else if (command == codes.marker)
        begin
            if (is_mark2)
            begin
                kind = ffcd_pkg::KIND_MARK2;
            end
            else if (is_mark3)
            begin
                kind = ffcd_pkg::KIND_MARK3;
            end
        end
    end

    always_comb
    begin
        event_set = '0;
        unique case (kind)
            ffcd_pkg::KIND_FOUND:  event_set[0] = 1'b1;
            ffcd_pkg::KIND_LOST:   event_set[1] = 1'b1;
            ffcd_pkg::KIND_CORNER: event_set[2] = 1'b1;
            ffcd_pkg::KIND_MARK2:  event_set[3] = 1'b1;
            ffcd_pkg::KIND_MARK3:  event_set[4] = 1'b1;
            default:               event_set = '0;
        endcase
    end

endmodule

// ----- design/ffcd_out_buf.sv -----
// ffcd_out_buf: result register with one skid entry on the output channel.
// Depends on ffcd_pkg (result_t).

module ffcd_out_buf
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ffcd_pkg::result_t push_data,
    output logic              full,
    output logic              out_valid,
    input  logic              out_stall,
    output ffcd_pkg::result_t out_data
);

    logic              out_valid_reg;
    ffcd_pkg::result_t out_data_reg;
    logic              skid_valid_reg;
    ffcd_pkg::result_t skid_data_reg;
    logic              out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (push)
            begin
                out_data_reg <= push_data;
            end
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

endmodule

// ----- design/fixed_frame_command_decoder.sv -----
// fixed_frame_command_decoder: top level, deframing state, event flags, config registers.
// Depends on ffcd_pkg, ffcd_decode and ffcd_out_buf.
//
//  channel | signals                                  | beat taken when
//  --------+------------------------------------------+-----------------------
//  in      | in_valid in_stall action rx_data          | in_valid && !in_stall
//          | event_select                              |
//  out     | out_valid out_stall frame_done msg_kind   | out_valid && !out_stall
//          | command data_one data_two pixel_offset    |
//          | angle_offset new_frame event_flags        |
//          | taken_value                               |
//  cfg     | cfg_write cfg_index cfg_data              | cfg_write
//
// One beat in, one beat out; a new input beat is taken every cycle while in_stall is low.
// Frame state and flags update at the input edge; the result is registered at that
// edge into the output register, or into the skid while it is stalled. The one-entry skid behind that register keeps
// the input open for one more beat while out_stall holds; in_stall rises only
// when both are full. Reset clears frame position, saved message, flags and
// loads the default head, tail and command codes.

module fixed_frame_command_decoder
(
    input  logic                 clk,
    input  logic                 rst_n,

    // configuration
    input  logic                 cfg_write,
    input  logic [2:0]           cfg_index,
    input  logic [7:0]           cfg_data,

    // input channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           action,
    input  logic [7:0]           rx_data,
    input  logic [2:0]           event_select,

    // output channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 frame_done,
    output logic [3:0]           msg_kind,
    output logic [7:0]           command,
    output logic [7:0]           data_one,
    output logic [7:0]           data_two,
    output logic signed [7:0]    pixel_offset,
    output logic signed [7:0]    angle_offset,
    output logic                 new_frame,
    output logic [4:0]           event_flags,
    output logic                 taken_value
);

    localparam int unsigned POS_W = ffcd_pkg::POS_W;
    localparam int unsigned IDX_W = ffcd_pkg::BODY_IDX_W;
    localparam int unsigned NEV   = ffcd_pkg::NUM_EVENTS;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [7:0]       head_reg;
    logic [7:0]       tail_reg;
    ffcd_pkg::codes_t codes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg        <= ffcd_pkg::HEAD_RST;
            tail_reg        <= ffcd_pkg::TAIL_RST;
            codes_reg       <= '{straight: ffcd_pkg::STRAIGHT_RST,
                                 arc:      ffcd_pkg::ARC_RST,
                                 found:    ffcd_pkg::FOUND_RST,
                                 lost:     ffcd_pkg::LOST_RST,
                                 corner:   ffcd_pkg::CORNER_RST,
                                 marker:   ffcd_pkg::MARKER_RST};
        end
        else if (cfg_write)
        begin
            unique case (ffcd_pkg::cfg_idx_t'(cfg_index))
                ffcd_pkg::CFG_HEAD:     head_reg         <= cfg_data;
                ffcd_pkg::CFG_TAIL:     tail_reg         <= cfg_data;
                ffcd_pkg::CFG_STRAIGHT: codes_reg.straight <= cfg_data;
                ffcd_pkg::CFG_ARC:      codes_reg.arc      <= cfg_data;
                ffcd_pkg::CFG_FOUND:    codes_reg.found    <= cfg_data;
                ffcd_pkg::CFG_LOST:     codes_reg.lost     <= cfg_data;
                ffcd_pkg::CFG_CORNER:   codes_reg.corner   <= cfg_data;
                ffcd_pkg::CFG_MARKER:   codes_reg.marker   <= cfg_data;
                default:                head_reg         <= head_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // frame and message state
    // ------------------------------------------------------------------
    logic [POS_W-1:0]      pos_reg,      pos_next;
    logic [7:0]            body_reg [ffcd_pkg::BODY_LEN];
    logic                  body_we;
    logic [IDX_W-1:0]      body_idx;
    ffcd_pkg::kind_t       kind_reg,     kind_next;
    logic [7:0]            cmd_reg,      cmd_next;
    logic [7:0]            d1_reg,       d1_next;
    logic [7:0]            d2_reg,       d2_next;
    logic                  fresh_reg,    fresh_next;
    logic [NEV-1:0]        events_reg,   events_next;

    logic                  accept;
    logic                  buf_full;
    logic                  done;
    logic                  taken;
    ffcd_pkg::kind_t       dec_kind;
    logic [NEV-1:0]        dec_events;
    ffcd_pkg::result_t     result;
    ffcd_pkg::result_t     out_data;

    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;
    assign body_idx = IDX_W'(pos_reg - POS_W'(1));

    // decode looks at the stored body; it is only used on the tail byte,
    // by which time all three entries hold this frame's bytes
    ffcd_decode u_decode
    (
        .codes     (codes_reg),
        .command   (body_reg[0]),
        .data_one  (body_reg[1]),
        .data_two  (body_reg[2]),
        .kind      (dec_kind),
        .event_set (dec_events)
    );

    always_comb
    begin
        pos_next    = pos_reg;
        kind_next   = kind_reg;
        cmd_next    = cmd_reg;
        d1_next     = d1_reg;
        d2_next     = d2_reg;
        fresh_next  = fresh_reg;
        events_next = events_reg;
        body_we     = 1'b0;
        done        = 1'b0;
        taken       = 1'b0;

        unique case (ffcd_pkg::action_t'(action))
            ffcd_pkg::ACT_BYTE:
            begin
                if (pos_reg == '0)
                begin
                    // idle: only the head byte opens a frame
                    if (rx_data == head_reg)
                    begin
                        pos_next = POS_W'(1);
                    end
                end
                else if (pos_reg < POS_W'(ffcd_pkg::FRAME_LEN - 1))
                begin
                    body_we  = 1'b1;
                    pos_next = pos_reg + POS_W'(1);
                end
                else
                begin
                    // tail: a bad tail drops the frame silently
                    pos_next = '0;
                    if (rx_data == tail_reg)
                    begin
                        cmd_next    = body_reg[0];
                        d1_next     = body_reg[1];
                        d2_next     = body_reg[2];
                        kind_next   = dec_kind;
                        events_next = events_reg | dec_events;
                        fresh_next  = (dec_kind != ffcd_pkg::KIND_INVALID);
                        done        = fresh_next;
                    end
                end
            end
            ffcd_pkg::ACT_CONSUME:
            begin
                // selectors past the last flag do nothing
                if (event_select < 3'(NEV))
                begin
                    taken                     = events_reg[event_select];
                    events_next[event_select] = 1'b0;
                end
            end
            ffcd_pkg::ACT_FETCH:
            begin
                taken      = fresh_reg;
                fresh_next = 1'b0;
            end
            ffcd_pkg::ACT_STATUS:
            begin
                taken = 1'b0;
            end
            default:
            begin
                taken = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            kind_reg   <= ffcd_pkg::KIND_NONE;
            cmd_reg    <= '0;
            d1_reg     <= '0;
            d2_reg     <= '0;
            fresh_reg  <= 1'b0;
            events_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg    <= pos_next;
            kind_reg   <= kind_next;
            cmd_reg    <= cmd_next;
            d1_reg     <= d1_next;
            d2_reg     <= d2_next;
            fresh_reg  <= fresh_next;
            events_reg <= events_next;
        end
    end

    // frame body bytes, no reset: each is written before the tail reads it
    always_ff @(posedge clk)
    begin
        if (accept && body_we)
        begin
            body_reg[body_idx] <= rx_data;
        end
    end

    // ------------------------------------------------------------------
    // result beat: state after this item's update
    // ------------------------------------------------------------------
    assign result = '{frame_done: done,
                      kind:       kind_next,
                      command:    cmd_next,
                      data_one:   d1_next,
                      data_two:   d2_next,
                      new_frame:  fresh_next,
                      events:     events_next,
                      taken:      taken};

    ffcd_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign frame_done   = out_data.frame_done;
    assign msg_kind     = out_data.kind;
    assign command      = out_data.command;
    assign data_one     = out_data.data_one;
    assign data_two     = out_data.data_two;
    assign pixel_offset = signed'(out_data.data_one);
    assign angle_offset = signed'(out_data.data_two);
    assign new_frame    = out_data.new_frame;
    assign event_flags  = out_data.events;
    assign taken_value  = out_data.taken;

endmodule

// ----- sim/tb_fixed_frame_command_decoder.sv -----
// tb_fixed_frame_command_decoder: self-checking bench for the fixed frame command decoder.
// Depends on ffcd_pkg and fixed_frame_command_decoder; a local status predictor
// checks every output beat against what the byte and action stream should give.

module tb_fixed_frame_command_decoder;

    timeunit 1ns;
    timeprecision 1ps;

    import ffcd_pkg::*;

    // run ends here even if the block hangs; far above the slowest legal run
    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned MAX_WAIT    = 9;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [2:0]           cfg_index;
    logic [7:0]           cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [1:0]           action;
    logic [7:0]           rx_data;
    logic [2:0]           event_select;
    logic                 out_valid;
    logic                 out_stall;
    logic                 frame_done;
    logic [3:0]           msg_kind;
    logic [7:0]           command;
    logic [7:0]           data_one;
    logic [7:0]           data_two;
    logic signed [7:0]    pixel_offset;
    logic signed [7:0]    angle_offset;
    logic                 new_frame;
    logic [4:0]           event_flags;
    logic                 taken_value;

    fixed_frame_command_decoder DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .rx_data      (rx_data),
        .event_select (event_select),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_done   (frame_done),
        .msg_kind     (msg_kind),
        .command      (command),
        .data_one     (data_one),
        .data_two     (data_two),
        .pixel_offset (pixel_offset),
        .angle_offset (angle_offset),
        .new_frame    (new_frame),
        .event_flags  (event_flags),
        .taken_value  (taken_value)
    );

    // ------------------------------------------------------------------
    // Status predictor: mirror of the deframer, flags and registers.
    // ------------------------------------------------------------------
    logic [2:0]            frame_pos;
    logic [7:0]            body [0:BODY_LEN-1];
    kind_t                 saved_kind;
    logic [7:0]            saved_cmd;
    logic [7:0]            saved_d1;
    logic [7:0]            saved_d2;
    logic                  fresh;
    logic [NUM_EVENTS-1:0] sticky;
    logic [7:0]            reg_head;
    logic [7:0]            reg_tail;
    codes_t                reg_codes;

    // expected output beats, oldest first
    result_t status_queue [$];

    int unsigned fail_count;
    int unsigned beats_sent;
    bit          no_idle;        // both sides draw no random gaps or stalls while set
    int unsigned hold_len;       // length of the next long receiver stall
    int unsigned hold_id;        // bumped by the sender to start that stall

    // Advance the predictor by one input beat and return the status it should show.
    function automatic result_t deframe_step(action_t act, logic [7:0] rx, logic [2:0] sel);
        result_t r;
        kind_t   k;
        logic    evt;
        r = '0;
        case (act)
            ACT_BYTE:
            begin
                if (frame_pos == 0)
                begin
                    // idle: only the head byte opens a frame
                    if (rx == reg_head)
                        frame_pos = 3'd1;
                end
                else if (frame_pos < FRAME_LEN - 1)
                begin
                    // body bytes are taken blindly, no resync on a head byte
                    body[frame_pos - 1] = rx;
                    frame_pos = frame_pos + 3'd1;
                end
                else
                begin
                    frame_pos = 3'd0;
                    // bad tail drops the frame, saved message untouched
                    if (rx == reg_tail)
                    begin
                        saved_cmd = body[0];
                        saved_d1  = body[1];
                        saved_d2  = body[2];
                        evt = (saved_d1 == DATA_EVENT) && (saved_d2 == DATA_EVENT);
                        // first matching code wins when codes overlap
                        if (saved_cmd == reg_codes.straight)
                            k = KIND_STRAIGHT;
                        else if (saved_cmd == reg_codes.arc)
                            k = KIND_ARC;
                        else if (saved_cmd == reg_codes.found)
                            k = evt ? KIND_FOUND : KIND_INVALID;
                        else if (saved_cmd == reg_codes.lost)
                            k = evt ? KIND_LOST : KIND_INVALID;
                        else if (saved_cmd == reg_codes.corner)
                            k = evt ? KIND_CORNER : KIND_INVALID;
                        else if (saved_cmd == reg_codes.marker)
                        begin
                            if (saved_d1 == DATA_MARK2 && saved_d2 == DATA_MARK2)
                                k = KIND_MARK2;
                            else if (saved_d1 == DATA_MARK3 && saved_d2 == DATA_MARK3)
                                k = KIND_MARK3;
                            else
                                k = KIND_INVALID;
                        end
                        else
                            k = KIND_INVALID;
                        saved_kind = k;
                        if (k >= KIND_FOUND)
                            sticky[k - KIND_FOUND] = 1'b1;
                        fresh = (k != KIND_INVALID);
                        r.frame_done = fresh;
                    end
                end
            end
            ACT_CONSUME:
            begin
                // selectors past the last flag consume nothing
                if (sel < NUM_EVENTS)
                begin
                    r.taken = sticky[sel];
                    sticky[sel] = 1'b0;
                end
            end
            ACT_FETCH:
            begin
                r.taken = fresh;
                fresh = 1'b0;
            end
            default:
            begin
            end
        endcase
        r.kind      = saved_kind;
        r.command   = saved_cmd;
        r.data_one  = saved_d1;
        r.data_two  = saved_d2;
        r.new_frame = fresh;
        r.events    = sticky;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset and timeout
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Output side: checks every beat taken and draws its own stalls
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    initial
    begin : result_monitor
        result_t     want;
        int unsigned hold_cnt;
        int unsigned stall_cnt;
        int unsigned hold_seen;
        hold_cnt  = 0;
        stall_cnt = 0;
        hold_seen = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (status_queue.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = status_queue.pop_front();
                    check_field("frame_done",   want.frame_done, frame_done);
                    check_field("msg_kind",     want.kind,       msg_kind);
                    check_field("command",      want.command,    command);
                    check_field("data_one",     want.data_one,   data_one);
                    check_field("data_two",     want.data_two,   data_two);
                    check_field("pixel_offset", want.data_one,   pixel_offset);
                    check_field("angle_offset", want.data_two,   angle_offset);
                    check_field("new_frame",    want.new_frame,  new_frame);
                    check_field("event_flags",  want.events,     event_flags);
                    check_field("taken_value",  want.taken,      taken_value);
                end
                // stall before the next beat, drawn per beat
                stall_cnt = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
            end
            // a long hold counts down here, independent of the sender
            if (hold_id != hold_seen)
            begin
                hold_seen = hold_id;
                hold_cnt  = hold_len;
            end
            if (hold_cnt > 0)
            begin
                out_stall <= 1'b1;
                hold_cnt--;
            end
            else if (stall_cnt > 0)
            begin
                out_stall <= 1'b1;
                stall_cnt--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one beat after a random gap, hold it until taken, then predict.
    task automatic send_item(action_t act, logic [7:0] rx, logic [2:0] sel);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        rx_data      <= rx;
        event_select <= sel;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        status_queue.push_back(deframe_step(act, rx, sel));
        beats_sent++;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_item(ACT_BYTE, b, 3'($urandom));
    endtask

    // Stop offering and let every expected beat come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (status_queue.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes one register; cfg_write never gets two updates in one step.
    task automatic write_reg(cfg_idx_t idx, logic [7:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_HEAD:     reg_head = val;
            CFG_TAIL:     reg_tail = val;
            CFG_STRAIGHT: reg_codes.straight = val;
            CFG_ARC:      reg_codes.arc = val;
            CFG_FOUND:    reg_codes.found = val;
            CFG_LOST:     reg_codes.lost = val;
            CFG_CORNER:   reg_codes.corner = val;
            default:      reg_codes.marker = val;
        endcase
        @(posedge clk);
    endtask

    task automatic program_regs(logic [7:0] h, logic [7:0] t, logic [7:0] s, logic [7:0] a,
                                logic [7:0] f, logic [7:0] l, logic [7:0] c, logic [7:0] m);
        wait_drained();
        write_reg(CFG_HEAD, h);
        write_reg(CFG_TAIL, t);
        write_reg(CFG_STRAIGHT, s);
        write_reg(CFG_ARC, a);
        write_reg(CFG_FOUND, f);
        write_reg(CFG_LOST, l);
        write_reg(CFG_CORNER, c);
        write_reg(CFG_MARKER, m);
    endtask

    task automatic send_frame(logic [7:0] h, logic [7:0] c, logic [7:0] d1, logic [7:0] d2,
                              logic [7:0] t);
        send_byte(h);
        send_byte(c);
        send_byte(d1);
        send_byte(d2);
        send_byte(t);
    endtask

    // Mostly well formed frame with random content; other actions may land mid frame.
    task automatic send_random_frame();
        logic [7:0] fb [0:4];
        int unsigned pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       fb[1] = reg_codes.straight;
            1:       fb[1] = reg_codes.arc;
            2:       fb[1] = reg_codes.found;
            3:       fb[1] = reg_codes.lost;
            4:       fb[1] = reg_codes.corner;
            5, 6:    fb[1] = reg_codes.marker;
            default: fb[1] = 8'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0:       begin fb[2] = DATA_EVENT; fb[3] = DATA_EVENT; end
            1:       begin fb[2] = DATA_MARK2; fb[3] = DATA_MARK2; end
            2:       begin fb[2] = DATA_MARK3; fb[3] = DATA_MARK3; end
            3:       begin fb[2] = DATA_EVENT; fb[3] = 8'($urandom); end
            default: begin fb[2] = 8'($urandom); fb[3] = 8'($urandom); end
        endcase
        fb[0] = reg_head;
        fb[4] = ($urandom_range(0, 9) < 8) ? reg_tail : 8'($urandom);
        for (int i = 0; i < FRAME_LEN; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                send_item(action_t'($urandom_range(1, 3)), 8'($urandom), 3'($urandom));
            send_byte(fb[i]);
        end
    endtask

    task automatic send_random_item();
        send_item(action_t'($urandom_range(0, 3)), 8'($urandom), 3'($urandom));
    endtask

    task automatic run_random(int unsigned n);
        int unsigned start;
        start = beats_sent;
        while (beats_sent - start < n)
        begin
            if ($urandom_range(0, 9) < 7)
                send_random_frame();
            else
                send_random_item();
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Status, fetch and consume straight out of reset, selectors 0 and 7.
    task automatic test_reset_status();
        send_item(ACT_STATUS, 8'hFF, 3'd7);
        send_item(ACT_FETCH, 8'h00, 3'd0);
        send_item(ACT_CONSUME, 8'h5A, 3'd0);
        send_item(ACT_CONSUME, 8'hA5, 3'd7);
    endtask

    // Tracking frames, dropped tail, invalid data, no resync, actions mid frame.
    task automatic test_frames();
        send_frame(HEAD_RST, STRAIGHT_RST, 8'h80, 8'h7F, TAIL_RST);
        send_item(ACT_FETCH, 8'h00, 3'd0);
        send_item(ACT_FETCH, 8'hFF, 3'd0);       // nothing new left
        send_frame(HEAD_RST, ARC_RST, 8'h11, 8'h22, 8'hFE);   // bad tail
        send_frame(HEAD_RST, FOUND_RST, 8'hAA, 8'h55, TAIL_RST); // event data wrong
        // a head byte inside the frame is data, not a restart
        send_byte(8'h00);
        send_frame(HEAD_RST, HEAD_RST, 8'h01, 8'h02, TAIL_RST);
        // other actions between frame bytes keep the frame going
        send_byte(HEAD_RST);
        send_byte(ARC_RST);
        send_item(ACT_STATUS, 8'hFF, 3'd3);
        send_item(ACT_CONSUME, HEAD_RST, 3'd6);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(TAIL_RST);
    endtask

    // Each event kind sets its flag; consume each, then out of range selectors.
    task automatic test_events();
        send_frame(HEAD_RST, FOUND_RST, DATA_EVENT, DATA_EVENT, TAIL_RST);
        send_frame(HEAD_RST, LOST_RST, DATA_EVENT, DATA_EVENT, TAIL_RST);
        send_frame(HEAD_RST, CORNER_RST, DATA_EVENT, DATA_EVENT, TAIL_RST);
        send_frame(HEAD_RST, MARKER_RST, DATA_MARK2, DATA_MARK2, TAIL_RST);
        send_frame(HEAD_RST, MARKER_RST, DATA_MARK3, DATA_MARK3, TAIL_RST);
        send_frame(HEAD_RST, MARKER_RST, DATA_MARK2, DATA_MARK3, TAIL_RST);
        for (int s = 0; s < 8; s++)
            send_item(ACT_CONSUME, 8'($urandom), 3'(s));
        send_item(ACT_CONSUME, 8'h00, 3'd2);     // already clear
    endtask

    // Register extremes, overlapping codes, and a code change mid frame.
    task automatic test_registers();
        // everything zero: all codes overlap, straight wins
        program_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_frame(8'h00, 8'h00, DATA_EVENT, DATA_EVENT, 8'h00);
        program_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_frame(8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF);
        // found, lost, corner and marker share a code: found wins
        program_regs(8'h5A, 8'hA5, 8'h01, 8'h02, 8'h10, 8'h10, 8'h10, 8'h10);
        send_frame(8'h5A, 8'h10, DATA_EVENT, DATA_EVENT, 8'hA5);
        send_frame(8'h5A, 8'h10, DATA_MARK2, DATA_MARK2, 8'hA5);
        // codes are read at the tail, the head only in idle
        send_byte(8'h5A);
        send_byte(8'h40);
        wait_drained();
        write_reg(CFG_HEAD, 8'h40);
        write_reg(CFG_STRAIGHT, 8'h40);
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'hA5);
    endtask

    // Receiver holds off under flat-out offers, a full drain pause, then random runs.
    task automatic test_backpressure();
        wait_drained();
        no_idle = 1'b1;
        hold_len = 80;
        hold_id++;
        for (int i = 0; i < 6; i++)
            send_random_frame();
        no_idle = 1'b0;
        wait_drained();
        run_random(40);
        // flat out on both sides for a while
        no_idle = 1'b1;
        run_random(60);
        no_idle = 1'b0;
    endtask

    // Random traffic under several register settings, defaults among them.
    task automatic test_random();
        program_regs(HEAD_RST, TAIL_RST, STRAIGHT_RST, ARC_RST,
                     FOUND_RST, LOST_RST, CORNER_RST, MARKER_RST);
        run_random(120);
        program_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        run_random(110);
        // narrow code range forces overlaps
        program_regs(8'($urandom), 8'($urandom),
                     8'($urandom_range(16, 19)), 8'($urandom_range(16, 19)),
                     8'($urandom_range(16, 19)), 8'($urandom_range(16, 19)),
                     8'($urandom_range(16, 19)), 8'($urandom_range(16, 19)));
        run_random(110);
        // head equal to tail
        reg_head = 8'($urandom);
        program_regs(reg_head, reg_head, 8'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        run_random(110);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n        <= 1'b0;
        cfg_write    <= 1'b0;
        cfg_index    <= CFG_HEAD;
        cfg_data     <= 8'h00;
        in_valid     <= 1'b0;
        action       <= ACT_STATUS;
        rx_data      <= 8'h00;
        event_select <= 3'd0;

        beats_sent   = 0;
        no_idle      = 1'b0;
        hold_len     = 0;
        hold_id      = 0;

        frame_pos  = 3'd0;
        saved_kind = KIND_NONE;
        saved_cmd  = 8'h00;
        saved_d1   = 8'h00;
        saved_d2   = 8'h00;
        fresh      = 1'b0;
        sticky     = '0;
        reg_head   = HEAD_RST;
        reg_tail   = TAIL_RST;
        reg_codes  = '{straight: STRAIGHT_RST, arc: ARC_RST, found: FOUND_RST,
                       lost: LOST_RST, corner: CORNER_RST, marker: MARKER_RST};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_status();
        test_frames();
        test_events();
        test_registers();
        test_backpressure();
        test_random();

        wait_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && status_queue.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
